// ----- rtl/pgs_pkg.sv -----
// Shared constants, codes and types of the pore Gillespie stepper.
package pgs_pkg;

	localparam int PORE_LOAD = 8;
	localparam int LAST_CELL = PORE_LOAD - 1;
	localparam int CNT_W = $clog2(PORE_LOAD + 2);

	localparam logic [CNT_W-1:0] CNT_TOP  = CNT_W'(PORE_LOAD + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PORE_LOAD);
	localparam logic [CNT_W-1:0] LR_INIT  = CNT_W'((PORE_LOAD + 1) / 2);
	localparam logic [CNT_W-1:0] RL_INIT  = CNT_W'(PORE_LOAD / 2);

	localparam logic [31:0] LN2_Q32 = 32'hB17217F7;

	localparam int STEP_W = 6;
	localparam logic [STEP_W-1:0] LOG_LAST = STEP_W'(31);
	localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(53);

	typedef enum logic [2:0] {
		REG_RATE_ON        = 3'd0,
		REG_RATE_OFF       = 3'd1,
		REG_RATE_HOP       = 3'd2,
		REG_INVERSE_VOLUME = 3'd3,
		REG_INITIAL_SOLUTE = 3'd4
	} pgs_reg_t;

	typedef enum logic [1:0] {
		TUBE_FULL  = 2'd0,
		TUBE_LEFT  = 2'd1,
		TUBE_RIGHT = 2'd2
	} pgs_tube_t;

	typedef enum logic [2:0] {
		EV_STALL         = 3'd0,
		EV_BIND_LEFT     = 3'd1,
		EV_BIND_RIGHT    = 3'd2,
		EV_LEFT_OFF      = 3'd3,
		EV_LEFT_TO_RIGHT = 3'd4,
		EV_RIGHT_OFF     = 3'd5,
		EV_RIGHT_TO_LEFT = 3'd6
	} pgs_event_t;

	typedef enum logic [1:0] {
		CROSS_NONE = 2'd0,
		CROSS_LR   = 2'd1,
		CROSS_RL   = 2'd2
	} pgs_cross_t;

	typedef enum logic [2:0] {
		S_IDLE, S_BIND_A, S_BIND_B, S_BIND_C, S_SUM, S_PICK, S_TAU, S_WRITE
	} pgs_ctl_state_t;

	typedef enum logic [2:0] {
		T_IDLE, T_NORM, T_LOG, T_LN_HI, T_LN_LO, T_DIV, T_DONE
	} pgs_tau_state_t;

	typedef struct packed {
		logic take_left;
		logic take_right;
	} pgs_shift_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] stamp;
	} pgs_entry_t;

endpackage

// ----- rtl/pore_gillespie_step.sv -----
// Top level of the pore Gillespie stepper: control, state, chain of hop-time cells.
//
// Input channel (in_valid/in_stall) takes one item of two random draws; output
// channel (out_valid/out_stall) returns one result item per input item.
// Items are worked one at a time: in_stall is high from acceptance until the
// result is loaded into the output register, which then frees the input side.
// A live step passes the control states and the time-step unit (normalise,
// log squaring, ln2 scaling and restoring division). A step with zero total
// propensity skips the time-step unit and goes straight to the output write.
// The user writes the configuration port (cfg_write_en, cfg_index, cfg_data)
// only while idle; the block itself does not enforce it.
// If the receiver stalls, the result holds in the output register; the next
// item may be accepted meanwhile but its result waits until the register frees.
// Reset (arst_n, asynchronous, low) restores default rates, clears the clock,
// the tube state and the hop-time valid bits, and reloads the crossing counters.
// Writing initial_solute also loads the solute count.
module pore_gillespie_step import pgs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] draw_time,
	input  logic [31:0] draw_pick,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] now_time,
	output logic [1:0]  pore_state,
	output logic [2:0]  event_kind,
	output logic        survival_valid,
	output logic [63:0] survival_span,
	output logic [1:0]  crossing,
	output logic [15:0] solute_now
);

	pgs_ctl_state_t state_q, state_d;

	logic [31:0] rate_on_q, rate_off_q, rate_hop_q, inv_vol_q;
	logic [63:0] clock_q;
	pgs_tube_t   tube_q;
	logic [15:0] solute_q;
	logic [CNT_W-1:0] lr_q, rl_q;

	logic [31:0] draw_time_q, draw_pick_q;
	logic [47:0] vol_q;
	logic [63:0] lo_q;
	logic [31:0] bind_q;
	logic [31:0] p1_q;
	logic [32:0] a0_q;
	logic [63:0] pick_q;
	logic [63:0] clk_new_q;
	logic        first_q;
	logic        stall_q;

	logic        out_valid_q;
	logic [63:0] now_time_q, span_q;
	logic [1:0]  pore_state_q, crossing_q;
	logic [2:0]  event_q;
	logic        sv_q;
	logic [15:0] solute_now_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [80:0] bsum;
	logic [31:0] p1_c, p2_c;
	logic [32:0] a0_c;
	logic        tau_start, tau_done;
	logic [53:0] tau;
	logic [64:0] csum;
	logic [64:0] lhs;
	logic        in_fire, write_fire;

	pgs_tube_t        tube_d;
	pgs_event_t       ev_d;
	pgs_cross_t       cross_d;
	logic [15:0]      sol_d;
	logic [CNT_W-1:0] lr_t, rl_t, lr_d, rl_d;
	logic [63:0]      clock_d, span_d;
	pgs_shift_t       shift_d, shift_en;
	pgs_entry_t       pop_d, fresh;
	pgs_entry_t       cell_out [PORE_LOAD];

	assign in_fire    = in_valid && !in_stall;
	assign write_fire = (state_q == S_WRITE) && (!out_valid_q || !out_stall);
	assign in_stall   = (state_q != S_IDLE);

	assign prod = mul_a * mul_b;
	assign bsum = {17'd0, lo_q} + {1'b0, prod[47:0], 32'd0};

	always_comb begin
		mul_a = {16'd0, solute_q};
		mul_b = inv_vol_q;
		unique case (state_q)
			S_BIND_B: begin
				mul_a = vol_q[31:0];
				mul_b = rate_on_q;
			end
			S_BIND_C: begin
				mul_a = {16'd0, vol_q[47:32]};
				mul_b = rate_on_q;
			end
			S_PICK: begin
				mul_a = a0_q[31:0];
				mul_b = draw_pick_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		p1_c = '0;
		p2_c = '0;
		case (tube_q) inside
			TUBE_FULL: begin
				p1_c = bind_q;
				p2_c = bind_q;
			end
			TUBE_LEFT, TUBE_RIGHT: begin
				p1_c = rate_off_q;
				p2_c = rate_hop_q;
			end
			default: ;
		endcase
	end

	assign a0_c      = {1'b0, p1_c} + {1'b0, p2_c};
	assign tau_start = (state_q == S_SUM) && (a0_c != 33'd0);
	assign csum      = {1'b0, clock_q} + {11'd0, tau};
	assign lhs       = {1'b0, pick_q} + (a0_q[32] ? {1'b0, draw_pick_q, 32'd0} : 65'd0);

	pgs_tau u_tau (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (tau_start),
		.draw_time (draw_time_q),
		.a0        (a0_q),
		.done      (tau_done),
		.tau       (tau)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_fire) state_d = S_BIND_A;
			S_BIND_A: state_d = S_BIND_B;
			S_BIND_B: state_d = S_BIND_C;
			S_BIND_C: state_d = S_SUM;
			S_SUM:    state_d = (a0_c == 33'd0) ? S_WRITE : S_PICK;
			S_PICK:   state_d = S_TAU;
			S_TAU:    if (tau_done) state_d = S_WRITE;
			S_WRITE:  if (write_fire) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			draw_time_q <= draw_time;
			draw_pick_q <= draw_pick;
		end
		unique case (state_q)
			S_BIND_A: vol_q <= prod[47:0];
			S_BIND_B: lo_q <= prod;
			S_BIND_C: bind_q <= (|bsum[80:56]) ? 32'hFFFF_FFFF : bsum[55:24];
			S_SUM: begin
				a0_q    <= a0_c;
				p1_q    <= p1_c;
				stall_q <= (a0_c == 33'd0);
			end
			S_PICK: pick_q <= prod;
			S_TAU: begin
				if (tau_done) begin
					clk_new_q <= csum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : csum[63:0];
					first_q   <= (lhs < {1'b0, p1_q, 32'd0});
				end
			end
			default: ;
		endcase
	end

	// step update
	always_comb begin
		tube_d   = tube_q;
		sol_d    = solute_q;
		lr_t     = lr_q;
		rl_t     = rl_q;
		ev_d     = EV_STALL;
		cross_d  = CROSS_NONE;
		shift_d  = '0;
		pop_d    = '0;
		clock_d  = stall_q ? clock_q : clk_new_q;
		if (!stall_q) begin
			case (tube_q)
				TUBE_FULL: begin
					ev_d   = first_q ? EV_BIND_LEFT : EV_BIND_RIGHT;
					tube_d = first_q ? TUBE_LEFT : TUBE_RIGHT;
					if (solute_q != 16'd0) sol_d = solute_q - 16'd1;
				end
				TUBE_LEFT: begin
					if (first_q) begin
						ev_d   = EV_LEFT_OFF;
						tube_d = TUBE_FULL;
						if (solute_q != 16'hFFFF) sol_d = solute_q + 16'd1;
					end else begin
						ev_d   = EV_LEFT_TO_RIGHT;
						tube_d = TUBE_RIGHT;
						lr_t   = lr_q + CNT_W'(1);
						if (rl_q != '0) rl_t = rl_q - CNT_W'(1);
						shift_d.take_left = 1'b1;
						pop_d = cell_out[LAST_CELL];
					end
				end
				TUBE_RIGHT: begin
					if (first_q) begin
						ev_d   = EV_RIGHT_OFF;
						tube_d = TUBE_FULL;
						if (solute_q != 16'hFFFF) sol_d = solute_q + 16'd1;
					end else begin
						ev_d   = EV_RIGHT_TO_LEFT;
						tube_d = TUBE_LEFT;
						rl_t   = rl_q + CNT_W'(1);
						if (lr_q != '0) lr_t = lr_q - CNT_W'(1);
						shift_d.take_right = 1'b1;
						pop_d = cell_out[0];
					end
				end
				default: ;
			endcase
		end
		lr_d = lr_t;
		rl_d = rl_t;
		if (lr_t == CNT_TOP) begin
			cross_d = CROSS_LR;
			lr_d    = CNT_FULL;
			rl_d    = '0;
		end else if (rl_t == CNT_TOP) begin
			cross_d = CROSS_RL;
			rl_d    = CNT_FULL;
			lr_d    = '0;
		end
		span_d = pop_d.valid ? (clk_new_q - pop_d.stamp) : 64'd0;
	end

	assign shift_en = write_fire ? shift_d : '0;
	assign fresh    = '{valid: 1'b1, stamp: clk_new_q};

	for (genvar i = 0; i < PORE_LOAD; i++) begin : g_cell
		pgs_entry_t left_in, right_in;
		if (i == 0) begin : g_head
			assign left_in = fresh;
		end else begin : g_mid_l
			assign left_in = cell_out[i-1];
		end
		if (i == LAST_CELL) begin : g_tail
			assign right_in = fresh;
		end else begin : g_mid_r
			assign right_in = cell_out[i+1];
		end
		pgs_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (shift_en),
			.from_left  (left_in),
			.from_right (right_in),
			.entry      (cell_out[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_on_q  <= 32'h0001_0000;
			rate_off_q <= 32'h0001_0000;
			rate_hop_q <= 32'h0001_0000;
			inv_vol_q  <= 32'h0100_0000;
			clock_q    <= '0;
			tube_q     <= TUBE_FULL;
			solute_q   <= '0;
			lr_q       <= LR_INIT;
			rl_q       <= RL_INIT;
		end else begin
			if (cfg_write_en) begin
				unique case (pgs_reg_t'(cfg_index))
					REG_RATE_ON:        rate_on_q  <= cfg_data;
					REG_RATE_OFF:       rate_off_q <= cfg_data;
					REG_RATE_HOP:       rate_hop_q <= cfg_data;
					REG_INVERSE_VOLUME: inv_vol_q  <= cfg_data;
					REG_INITIAL_SOLUTE: solute_q   <= cfg_data[15:0];
					default: ;
				endcase
			end else if (write_fire) begin
				solute_q <= sol_d;
			end
			if (write_fire) begin
				clock_q <= clock_d;
				tube_q  <= tube_d;
				lr_q    <= lr_d;
				rl_q    <= rl_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (write_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (write_fire) begin
			now_time_q   <= clock_d;
			pore_state_q <= tube_d;
			event_q      <= ev_d;
			sv_q         <= pop_d.valid;
			span_q       <= span_d;
			crossing_q   <= cross_d;
			solute_now_q <= sol_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign now_time       = now_time_q;
	assign pore_state     = pore_state_q;
	assign event_kind     = event_q;
	assign survival_valid = sv_q;
	assign survival_span  = span_q;
	assign crossing       = crossing_q;
	assign solute_now     = solute_now_q;

endmodule

// ----- rtl/pgs_cell.sv -----
// One hop-time cell of the bidirectional shift chain.
module pgs_cell import pgs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  pgs_shift_t shift,
	input  pgs_entry_t from_left,
	input  pgs_entry_t from_right,
	output pgs_entry_t entry
);

	logic        valid_q;
	logic [63:0] stamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift.take_left) begin
			valid_q <= from_left.valid;
		end else if (shift.take_right) begin
			valid_q <= from_right.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift.take_left) begin
			stamp_q <= from_left.stamp;
		end else if (shift.take_right) begin
			stamp_q <= from_right.stamp;
		end
	end

	assign entry = '{valid: valid_q, stamp: stamp_q};

endmodule

// ----- rtl/pgs_tau.sv -----
// Iterative time-step unit: normalise, log2 by squaring, scale by ln2, divide by a0.
module pgs_tau import pgs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] draw_time,
	input  logic [32:0] a0,
	output logic        done,
	output logic [53:0] tau
);

	pgs_tau_state_t state_q, state_d;

	logic [31:0]       m_q;
	logic [4:0]        e_q;
	logic [31:0]       frac_q;
	logic [31:0]       acc_q;
	logic [53:0]       num_q;
	logic [32:0]       rem_q;
	logic [STEP_W-1:0] cnt_q;

	logic [37:0] v;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [32:0] sq_top;
	logic [37:0] ln_sum;
	logic [33:0] trial;
	logic [34:0] diff;
	logic        ge;

	assign v      = {6'd32, 32'd0} - {1'b0, e_q, frac_q};
	assign prod   = mul_a * mul_b;
	assign sq_top = prod[63:31];
	assign ln_sum = prod[37:0] + {6'd0, acc_q};
	assign trial  = {rem_q, num_q[53]};
	assign diff   = {1'b0, trial} - {2'b00, a0};
	assign ge     = ~diff[34];

	always_comb begin
		mul_a = m_q;
		mul_b = m_q;
		unique case (state_q)
			T_LN_HI: begin
				mul_a = v[31:0];
				mul_b = LN2_Q32;
			end
			T_LN_LO: begin
				mul_a = {26'd0, v[37:32]};
				mul_b = LN2_Q32;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			T_IDLE:  if (start) state_d = T_NORM;
			T_NORM:  if (m_q[31]) state_d = T_LOG;
			T_LOG:   if (cnt_q == LOG_LAST) state_d = T_LN_HI;
			T_LN_HI: state_d = T_LN_LO;
			T_LN_LO: state_d = T_DIV;
			T_DIV:   if (cnt_q == DIV_LAST) state_d = T_DONE;
			T_DONE:  state_d = T_IDLE;
			default: state_d = T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			T_IDLE: begin
				m_q <= (draw_time == 32'd0) ? 32'd1 : draw_time;
				e_q <= 5'd31;
			end
			T_NORM: begin
				if (m_q[31]) begin
					cnt_q  <= '0;
					frac_q <= '0;
				end else begin
					m_q <= {m_q[30:0], 1'b0};
					e_q <= e_q - 5'd1;
				end
			end
			T_LOG: begin
				frac_q <= {frac_q[30:0], sq_top[32]};
				m_q    <= sq_top[32] ? sq_top[32:1] : sq_top[31:0];
				cnt_q  <= cnt_q + STEP_W'(1);
			end
			T_LN_HI: acc_q <= prod[63:32];
			T_LN_LO: begin
				num_q <= {ln_sum, 16'd0};
				rem_q <= '0;
				cnt_q <= '0;
			end
			T_DIV: begin
				num_q <= {num_q[52:0], ge};
				rem_q <= ge ? diff[32:0] : trial[32:0];
				cnt_q <= cnt_q + STEP_W'(1);
			end
			default: ;
		endcase
	end

	assign done = (state_q == T_DONE);
	assign tau  = num_q;

endmodule
